[src/int_to_decimal_ascii_top_macros.svh]
// Assertion helpers, clocked on i_clk.
`ifndef INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Checked only while out of reset.
`define ITDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ITDA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/itda_pkg.sv]
`default_nettype none

package itda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CODE_W     = 6;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [CODE_W-1:0] CHAR_ZERO  = CODE_W'(48);
    localparam logic [CODE_W-1:0] CHAR_MINUS = CODE_W'(45);

    typedef logic [BCD_W-1:0] t_bcd;

    // add-3 correction on every BCD digit of 5 or more, ahead of a left shift
    function automatic t_bcd bcd_adjust(input t_bcd bcd);
        t_bcd res;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/int_to_decimal_ascii_top.sv]
// Channel  | Direction | Handshake            | Ports
// item in  | input     | start & !busy        | i_value
// item out | output    | o_valid, one cycle   | o_char_code, o_last
//
// Magnitude to BCD by shift-and-add-3, one bit per cycle.
// Leading zeros are then dropped at one digit per cycle (up to 9 digits, the last digit always kept),
// and the text leaves at one character per cycle (1 to 11 characters).
// Reset (i_rst_n low, synchronous) returns the sequencer to idle, no strobe.
// The receiver cannot stall; characters of one item leave back to back.
`default_nettype none

module int_to_decimal_ascii_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire logic signed [itda_pkg::VALUE_W-1:0] i_value,
    output logic                                     busy,
    output logic                                     o_valid,
    output logic             [itda_pkg::CODE_W-1:0]  o_char_code,
    output logic                                     o_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SKIP = 3'd2;
    localparam logic [2:0] S_SIGN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]                         r_state, n_state;
    logic [itda_pkg::VALUE_W-1:0]       r_bin, n_bin;
    itda_pkg::t_bcd                     r_bcd, n_bcd;
    logic [itda_pkg::BIT_CNT_W-1:0]     r_bit, n_bit;
    logic [itda_pkg::DIG_CNT_W-1:0]     r_cnt, n_cnt;
    logic                               r_neg, n_neg;
    logic                               r_valid, n_valid;
    logic [itda_pkg::CODE_W-1:0]        r_char, n_char;
    logic                               r_last, n_last;

    itda_pkg::t_bcd                     bcd_adj;
    logic [3:0]                         top_dig;

    assign bcd_adj = itda_pkg::bcd_adjust(r_bcd);
    assign top_dig = r_bcd[itda_pkg::BCD_W-1 -: 4];

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_bit   = r_bit;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_neg   = i_value[itda_pkg::VALUE_W-1];
                    n_bin   = i_value[itda_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
                    n_bcd   = '0;
                    n_bit   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                {n_bcd, n_bin} = {bcd_adj[itda_pkg::BCD_W-2:0], r_bin, 1'b0};
                n_bit          = r_bit + 1'b1;
                if (r_bit == itda_pkg::BIT_CNT_W'(itda_pkg::VALUE_W - 1)) begin
                    n_cnt   = itda_pkg::DIG_CNT_W'(itda_pkg::NUM_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (top_dig == 4'd0 && r_cnt > itda_pkg::DIG_CNT_W'(1)) begin
                    n_bcd = {r_bcd[itda_pkg::BCD_W-5:0], 4'd0};
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                n_valid = 1'b1;
                n_char  = itda_pkg::CHAR_MINUS;
                n_last  = 1'b0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_valid = 1'b1;
                n_char  = itda_pkg::CHAR_ZERO + {2'b00, top_dig};
                n_last  = (r_cnt == itda_pkg::DIG_CNT_W'(1));
                n_bcd   = {r_bcd[itda_pkg::BCD_W-5:0], 4'd0};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == itda_pkg::DIG_CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_bit  <= n_bit;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

`include "int_to_decimal_ascii_top_macros.svh"

    `ITDA_ASSERT(a_accept_busy, start && !busy |=> busy && !o_valid, "accept did not start work")
    `ITDA_ASSERT(a_run_contig, o_valid && !o_last |=> o_valid, "gap inside one item's text")
    `ITDA_ASSERT(a_more_busy, o_valid && !o_last |-> busy, "idle while text remains")
    `ITDA_ASSERT(a_minus_not_last, o_valid && o_char_code == itda_pkg::CHAR_MINUS |-> !o_last, "sign flagged last")
    `ITDA_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_valid && !busy, "activity after reset")

endmodule

`default_nettype wire

[test/testbench.sv]
`default_nettype none

module testbench;

    typedef struct {
        logic [itda_pkg::VALUE_W-1:0] value;
        int unsigned                  gap;
        bit                           drain;
    } t_number_req;

    typedef struct {
        logic [itda_pkg::CODE_W-1:0] code;
        logic                        last;
    } t_text_char;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic signed [itda_pkg::VALUE_W-1:0] i_value = '0;
    logic                                busy;
    logic                                o_valid;
    logic [itda_pkg::CODE_W-1:0]         o_char_code;
    logic                                o_last;

    t_number_req pending[$];
    t_text_char  text_q[$];
    t_number_req nxt;
    t_text_char  exp_c;
    logic        took = 1'b0;
    int unsigned hold_left = 0;
    int          errors = 0;
    int          items_taken = 0;
    int          negatives_taken = 0;
    int          chars_seen = 0;

    int_to_decimal_ascii_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_value     (i_value),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected text of one number, most significant character first
    function automatic void queue_decimal_text(logic [itda_pkg::VALUE_W-1:0] v);
        logic [itda_pkg::VALUE_W-1:0] mag;
        logic [3:0]                   digs[itda_pkg::NUM_DIGITS];
        int                           nd;
        t_text_char                   c;
        mag = v[itda_pkg::VALUE_W-1] ? (32'd0 - v) : v;
        nd = 1;
        for (int k = 0; k < itda_pkg::NUM_DIGITS; k++) begin
            digs[k] = 4'(mag % 10);
            if (digs[k] != 4'd0) nd = k + 1;
            mag = mag / 10;
        end
        if (v[itda_pkg::VALUE_W-1]) begin
            c.code = itda_pkg::CHAR_MINUS;
            c.last = 1'b0;
            text_q.push_back(c);
        end
        for (int d = nd - 1; d >= 0; d--) begin
            c.code = itda_pkg::CHAR_ZERO + itda_pkg::CODE_W'(digs[d]);
            c.last = (d == 0);
            text_q.push_back(c);
        end
    endfunction

    function automatic logic [itda_pkg::VALUE_W-1:0] pick_value();
        longint      mag;
        longint      lo;
        longint      hi;
        int unsigned n;
        int unsigned r;
        bit          neg;
        r = $urandom_range(0, 9);
        neg = 1'($urandom_range(0, 1));
        if (r < 3) return $urandom();
        if (r < 8) begin
            // uniform over text lengths
            n = $urandom_range(1, 10);
            lo = 1;
            for (int k = 1; k < n; k++) lo = lo * 10;
            hi = lo * 10 - 1;
            if (n == 1) lo = 0;
            if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
            mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
        end else if (r == 8) begin
            mag = 1;
            n = $urandom_range(0, 9);
            for (int k = 0; k < n; k++) mag = mag * 10;
            mag = mag + longint'($urandom_range(0, 2)) - 1;
        end else begin
            mag = $urandom_range(0, 20);
        end
        return neg ? 32'(-mag) : 32'(mag);
    endfunction

    function automatic int unsigned pick_gap(int unsigned idx);
        int unsigned r;
        if ((idx / 30) % 3 == 1) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 4);
        return $urandom_range(10, 70);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !took)) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                start <= 1'b0;
            end else if (pending.size() > 0 && (!pending[0].drain || text_q.size() == 0)) begin
                nxt = pending.pop_front();
                start <= 1'b1;
                i_value <= nxt.value;
                hold_left <= nxt.gap;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            took <= 1'b0;
        end else begin
            took <= start && !busy;
            if (o_valid === 1'b1) begin
                if (text_q.size() == 0) begin
                    $error("unexpected character: char_code %0d last %0b", o_char_code, o_last);
                    errors++;
                end else begin
                    exp_c = text_q.pop_front();
                    chars_seen++;
                    if (o_char_code !== exp_c.code) begin
                        $error("char_code: expected %0d, got %0d", exp_c.code, o_char_code);
                        errors++;
                    end
                    if (o_last !== exp_c.last) begin
                        $error("last: expected %0b, got %0b", exp_c.last, o_last);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                queue_decimal_text(i_value);
                items_taken++;
                if (i_value[itda_pkg::VALUE_W-1]) negatives_taken++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[int_to_decimal_ascii_top] ERROR");
        $finish;
    end

    initial begin
        logic [itda_pkg::VALUE_W-1:0] directed[$];
        t_number_req                  req;
        directed = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
                     32'd100, -32'sd100, 32'd123456789, -32'sd123456789, 32'd999999999,
                     32'd1000000000, -32'sd1000000000, 32'd1000000001, 32'd2147483646,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE,
                     32'd4000000000, 32'd5};
        foreach (directed[i]) begin
            req.value = directed[i];
            req.gap = (i % 4 == 3) ? $urandom_range(1, 40) : 0;
            req.drain = (i == directed.size() - 1);
            pending.push_back(req);
        end
        for (int unsigned i = 0; i < 430; i++) begin
            req.value = pick_value();
            req.gap = pick_gap(i);
            req.drain = ($urandom_range(0, 99) < 3);
            pending.push_back(req);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (pending.size() > 0 || start || text_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("%0d numbers formatted (%0d negative), %0d characters checked",
                 items_taken, negatives_taken, chars_seen);
        if (errors == 0) begin
            $display("[int_to_decimal_ascii_top] OK");
        end else begin
            $display("[int_to_decimal_ascii_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
